// ===== src/srng_pkg.sv =====
// ----------------------------------------------------------------------------
// srng_pkg
// Shared constants and arithmetic for the shuffled minimal-standard RNG.
// ----------------------------------------------------------------------------
package srng_pkg;

    // Shuffle table geometry (power of two, 4..256)
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Generator word and multiplier
    localparam int VALUE_W = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = VALUE_W + MULT_W;

    localparam logic [VALUE_W-1:0] MODULUS = {VALUE_W{1'b1}};
    localparam logic [MULT_W-1:0]  MULT    = MULT_W'(16807);

    // Slot select: last output / (1 + (M-1)/N) is a right shift for N = 2^k
    localparam int SLOT_SHIFT = VALUE_W - IDX_W;

    // Reseed sequence: warm-up steps then one step per table entry
    localparam int WARMUP_STEPS = 8;
    localparam int LAST_STEP    = WARMUP_STEPS + TABLE_ENTRIES - 1;
    localparam int CNT_W        = $clog2(LAST_STEP + 1);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [IDX_W-1:0]   idx_t;

    // Fold a product modulo 2^31-1: low part plus high part, one subtract
    function automatic value_t mod_fold(input prod_t p);
        logic [VALUE_W:0] sum;
        sum = {1'b0, p[VALUE_W-1:0]} + (VALUE_W+1)'(p[PROD_W-1:VALUE_W]);
        if (sum >= {1'b0, MODULUS}) begin
            sum = sum - {1'b0, MODULUS};
        end
        return sum[VALUE_W-1:0];
    endfunction

endpackage

// ===== src/srng_ram.sv =====
// ----------------------------------------------------------------------------
// srng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/shuffled_minimal_standard_rng_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng_core
// Park-Miller generator (x * 16807 mod 2^31-1) behind a Bays-Durham shuffle.
// ----------------------------------------------------------------------------
//  channel  | ports                              | word
//  ---------+------------------------------------+---------------------------
//  request  | s_valid, s_ready, s_restart        | restart flag
//  result   | m_valid, m_ready, m_random_value   | 31-bit shuffled value
//  config   | cfg_wr_en, cfg_wr_data             | seed, no wait
//
//  A request passes accept, multiply, then fold and table swap; one shared
//  multiply-then-fold unit runs every generator step as a multiply state
//  and a fold state. A reseed (restart set, or first request after reset)
//  adds 8 warm-up steps and 32 table fills through the same unit.
//  Reset is synchronous, active low; the table needs no clearing.
//  s_ready is low while a word is in progress or waits on m_ready.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_rng_core
    import srng_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    // Request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_random_value
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]     state_reg, state_next;
    value_t         seed_reg;
    value_t         gen_reg, gen_next;
    value_t         last_reg, last_next;
    prod_t          prod_reg;
    logic           seeding_reg, seeding_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           m_valid_reg, m_valid_next;
    value_t         out_reg;
    logic           out_load;

    value_t         seed_fixed;
    value_t         gen_step;
    idx_t           slot;
    idx_t           fill_idx;
    logic           ram_wr_en;
    idx_t           ram_wr_addr;
    value_t         ram_rd_data;
    logic           s_accept;

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_random_value = out_reg;

    // Seed of 0 or of the modulus would lock the generator; use 1
    assign seed_fixed = (seed_reg == '0 || seed_reg == MODULUS) ? value_t'(1) : seed_reg;

    // Table slot from the top bits of the last output
    assign slot     = last_reg[SLOT_SHIFT +: IDX_W];
    assign fill_idx = IDX_W'(LAST_STEP - int'(cnt_reg));
    assign gen_step = mod_fold(prod_reg);

    // Shuffle table
    srng_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (gen_step),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        last_next    = last_reg;
        seeding_next = seeding_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        out_load     = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = slot;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MUL;
                    if (s_restart || last_reg == '0) begin
                        gen_next     = seed_fixed;
                        seeding_next = 1'b1;
                        cnt_next     = '0;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                gen_next = gen_step;
                if (seeding_reg) begin
                    // Warm-up, then fill from the last entry down to entry 0
                    state_next = ST_MUL;
                    if (cnt_reg >= CNT_W'(WARMUP_STEPS)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = fill_idx;
                    end
                    if (cnt_reg == CNT_W'(LAST_STEP)) begin
                        last_next    = gen_step;
                        seeding_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    // Swap: old entry out, new generator value in
                    ram_wr_en    = 1'b1;
                    last_next    = ram_rd_data;
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= value_t'(1);
            gen_reg     <= '0;
            last_reg    <= '0;
            seeding_reg <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            last_reg    <= last_next;
            seeding_reg <= seeding_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers: product and output word
    always_ff @(posedge aclk) begin
        prod_reg <= prod_t'(gen_reg) * prod_t'(MULT);
        if (out_load) begin
            out_reg <= ram_rd_data;
        end
    end

endmodule
